// ===== rtl/aab_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aab_pkg
// Shared types and constants for the annular arc angular binning block.
// ----------------------------------------------------------------------------
package aab_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int Z_BITS       = 34;   // Q30 angle accumulator, signed
  localparam int COUNT_BITS   = 24;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic signed [Z_BITS-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [Z_BITS-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic [2:0] CFG_INNER = 3'd0;
  localparam logic [2:0] CFG_OUTER = 3'd1;
  localparam logic [2:0] CFG_START = 3'd2;
  localparam logic [2:0] CFG_SWEEP = 3'd3;
  localparam logic [2:0] CFG_BINS  = 3'd4;

  typedef enum logic [9:0] {
    ST_CLEAR  = 10'b00_0000_0001,
    ST_IDLE   = 10'b00_0000_0010,
    ST_CORDIC = 10'b00_0000_0100,
    ST_ANGLE  = 10'b00_0000_1000,
    ST_SECTOR = 10'b00_0001_0000,
    ST_MUL    = 10'b00_0010_0000,
    ST_DIV    = 10'b00_0100_0000,
    ST_READ   = 10'b00_1000_0000,
    ST_WRITE  = 10'b01_0000_0000,
    ST_OUT    = 10'b10_0000_0000
  } state_t;

  function automatic logic signed [Z_BITS-1:0] atan_step(input logic [4:0] i);
    logic signed [Z_BITS-1:0] v;
    case (i)
      5'd0: v = 34'sd843314857;
      5'd1: v = 34'sd497837829;
      5'd2: v = 34'sd263043837;
      5'd3: v = 34'sd133525159;
      5'd4: v = 34'sd67021687;
      5'd5: v = 34'sd33543516;
      5'd6: v = 34'sd16775851;
      5'd7: v = 34'sd8388437;
      5'd8: v = 34'sd4194283;
      5'd9: v = 34'sd2097149;
      default: v = Z_BITS'(34'sd1 <<< (5'd30 - i));
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/aab_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aab_ram
// Generic single-port write, single-port read RAM with registered read data.
// ----------------------------------------------------------------------------
module aab_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/annular_arc_angular_binning.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annular_arc_angular_binning
// Annular sector test with angular binning and a per-bin pixel histogram.
// ----------------------------------------------------------------------------
// Usage: one request carries a pixel offset (in_row_offset, in_col_offset)
// from the arc center on a valid/ready channel. Each request gives exactly one
// result (out_inside_res, out_bin_index, out_bin_total) on a valid/ready
// output channel; the histogram count of the hit bin is incremented and the
// new value returned, saturating at 2^24-1.
// One request is in flight at a time. A pixel outside the annulus has its
// result valid in the cycle after acceptance. A pixel outside the angular
// sector goes through 30 CORDIC iterations, a rounding state and a sector
// state. An inside pixel goes through those, then a multiply state, the
// restoring divider for the bin, a memory read and a write back.
// The CORDIC and the divider are the iterative units of the block.
// Reset (rst_n low, synchronous) loads register defaults and starts a clear
// sweep of the histogram memory, one entry per cycle;
// no request is taken until it ends. Configuration writes (cfg_wr_en) apply
// at once and are meant only while the block is idle. When the receiver
// stalls, the result holds on the output and no new request is accepted.
// ----------------------------------------------------------------------------
module annular_arc_angular_binning #(
  parameter int MAX_BINS        = 16384,
  parameter int COORD_BITS      = 12,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [2:0]                   cfg_index,
  input  logic [16:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_row_offset,
  input  logic signed [COORD_BITS-1:0] in_col_offset,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_inside_res,
  output logic [13:0]                  out_bin_index,
  output logic [23:0]                  out_bin_total
);
  import aab_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam int BW = AW + 1;                 // holds MAX_BINS itself
  localparam int SH = 30 - ANGLE_FRAC_BITS;
  localparam int AB = ANGLE_FRAC_BITS + 6;    // wide enough for +-4pi
  localparam int NB = AB + BW + 1;            // dividend 2*num*(bins-1)+den
  localparam int QB = NB;
  localparam int XY_BITS = COORD_BITS + 44;   // guard-scaled vector, CORDIC gain
  localparam logic signed [Z_BITS-1:0] HALF_RND = Z_BITS'(1) <<< (SH - 1);
  localparam logic [BW-1:0] MAXB = BW'(MAX_BINS);

  state_t state_r, state_nxt;

  logic [10:0] inner_r, outer_r;
  logic signed [15:0] start_r;
  logic signed [16:0] sweep_r;
  logic [14:0] bins_r;

  logic signed [XY_BITS-1:0] x_r, y_r;
  logic signed [Z_BITS-1:0]  z_r;
  logic [4:0] it_r;
  logic [AW:0] clr_r;

  logic signed [AB-1:0] t_r;
  logic [AB-2:0] num_r, den_r;
  logic [NB-1:0] rem_r, dvd_r;
  logic [NB-1:0] dsr_r;
  logic [QB-1:0] q_r;
  logic [$clog2(NB+1)-1:0] dcnt_r;
  logic [BW-1:0] bm1_r;
  logic [AW-1:0] idx_r;
  logic inside_r;
  logic [COUNT_BITS-1:0] cnt_r;

  logic ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [COUNT_BITS-1:0] ram_wd, ram_rd;

  aab_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_BINS)) u_hist (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
    .rd_addr(ram_ra), .rd_data(ram_rd)
  );

  // ---- radius test (combinational at accept) ----
  logic signed [2*COORD_BITS-1:0] rsq, csq;
  logic [2*COORD_BITS:0] d2;
  logic [21:0] ro2, ri2;
  logic rad_ok;
  always_comb begin
    rsq = in_row_offset * in_row_offset;
    csq = in_col_offset * in_col_offset;
    d2  = (2*COORD_BITS+1)'($unsigned(rsq)) + (2*COORD_BITS+1)'($unsigned(csq));
    ro2 = outer_r * outer_r;
    ri2 = inner_r * inner_r;
    rad_ok = !((2*COORD_BITS+23)'(d2) > (2*COORD_BITS+23)'(ro2)) &&
             !((2*COORD_BITS+23)'(d2) < (2*COORD_BITS+23)'(ri2));
  end

  // CORDIC vector x = col, y = -row
  logic signed [COORD_BITS+1:0] cx, cy;
  assign cx = (COORD_BITS+2)'(in_col_offset);
  assign cy = -(COORD_BITS+2)'(in_row_offset);

  // ---- CORDIC step ----
  logic signed [XY_BITS-1:0] xs, ys;
  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;

  // ---- angle rounding and wrap on final z ----
  logic signed [Z_BITS-1:0] zr;
  logic signed [AB-1:0] tpi, tpi2, t0, tw;
  always_comb begin
    tpi  = AB'((PI_Q30 + HALF_RND) >>> SH);
    tpi2 = tpi <<< 1;
    if (z_r >= 0) zr = (z_r + HALF_RND) >>> SH;
    else          zr = -((-z_r + HALF_RND) >>> SH);
    t0 = AB'(zr);
    tw = t0;
    if (tw > tpi) tw = tw - tpi2;
    if (tw <= -tpi) tw = tw + tpi2;
  end

  // ---- sector test and unwrap on the registered angle ----
  logic signed [AB-1:0] a, b, tu, num;
  logic signed [AB-1:0] sw, den;
  logic sec_ok;

  function automatic logic span(input logic signed [AB-1:0] lo, hi, t);
    return (lo <= t && t < hi) || (hi < t && t <= lo);
  endfunction

  always_comb begin
    a  = AB'(start_r);
    sw = AB'(sweep_r);
    b  = a + sw;
    sec_ok = (span(a, b, t_r - tpi2) || span(a, b, t_r) || span(a, b, t_r + tpi2))
             && (sw != 0);
    tu = t_r;
    if (sw > 0 && t_r < a) tu = t_r + tpi2;
    else if (sw < 0 && t_r > a) tu = t_r - tpi2;
    num = tu - a;
    if (num < 0) num = -num;
    den = (sw < 0) ? -sw : sw;
  end

  logic [BW-1:0] bins_c;
  always_comb begin
    bins_c = (bins_r == 0) ? BW'(1) : BW'(bins_r);
    if ((BW+15)'(bins_r) > (BW+15)'(MAXB)) bins_c = MAXB;
  end

  logic [AB+BW-1:0] prod;
  assign prod = {num_r, 1'b0} * bm1_r;

  // divider step
  logic [NB:0] trial;
  assign trial = {rem_r, dvd_r[NB-1]} - {1'b0, dsr_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_r == (AW+1)'(MAX_BINS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = rad_ok ? ST_CORDIC : ST_OUT;
      ST_CORDIC: if (it_r == 5'(CORDIC_STEPS - 1)) state_nxt = ST_ANGLE;
      ST_ANGLE:  state_nxt = ST_SECTOR;
      ST_SECTOR: state_nxt = sec_ok ? ST_MUL : ST_OUT;
      ST_MUL:    state_nxt = ST_DIV;
      ST_DIV:    if (dcnt_r == 1) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_WRITE;
      ST_WRITE:  state_nxt = ST_OUT;
      ST_OUT:    if (out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_inside_res = inside_r;
  assign out_bin_index  = inside_r ? 14'(idx_r) : 14'd0;
  assign out_bin_total  = inside_r ? cnt_r : '0;

  logic [QB-1:0] qclamp;
  logic [COUNT_BITS-1:0] inc;
  always_comb begin
    qclamp = q_r;
    if (q_r > QB'(bm1_r)) qclamp = QB'(bm1_r);
    inc = (ram_rd == COUNT_MAX) ? ram_rd : ram_rd + 1'b1;
  end

  always_comb begin
    ram_we = 1'b0;
    ram_wa = idx_r;
    ram_wd = inc;
    ram_ra = AW'(qclamp);
    if (state_r == ST_CLEAR) begin
      ram_we = 1'b1;
      ram_wa = clr_r[AW-1:0];
      ram_wd = '0;
    end else if (state_r == ST_WRITE) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      inner_r  <= 11'd0;
      outer_r  <= 11'd1;
      start_r  <= 16'sd0;
      sweep_r  <= 17'sd25736;
      bins_r   <= 15'd1;
      inside_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_INNER: inner_r <= cfg_data[10:0];
          CFG_OUTER: outer_r <= cfg_data[10:0];
          CFG_START: start_r <= cfg_data[15:0];
          CFG_SWEEP: sweep_r <= cfg_data;
          CFG_BINS:  bins_r  <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (state_r == ST_IDLE && in_valid) inside_r <= 1'b0;
      if (state_r == ST_READ) inside_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        it_r <= '0;
        if (cx == 0 && cy == 0) begin
          z_r <= -HALF_PI_Q30; x_r <= '0; y_r <= '0;
        end else if (cx < 0) begin
          z_r <= (cy >= 0) ? PI_Q30 : -PI_Q30;
          x_r <= XY_BITS'(-cx) <<< 40;
          y_r <= XY_BITS'(-cy) <<< 40;
        end else begin
          z_r <= '0;
          x_r <= XY_BITS'(cx) <<< 40;
          y_r <= XY_BITS'(cy) <<< 40;
        end
      end
      ST_CORDIC: begin
        it_r <= it_r + 1'b1;
        if (!(x_r == 0 && y_r == 0)) begin
          if (y_r >= 0) begin
            x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + atan_step(it_r);
          end else begin
            x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - atan_step(it_r);
          end
        end
      end
      ST_ANGLE: t_r <= tw;
      ST_SECTOR: begin
        num_r <= num[AB-2:0];
        den_r <= den[AB-2:0];
        bm1_r <= bins_c - 1'b1;
      end
      ST_MUL: begin
        dvd_r <= NB'(prod) + NB'(den_r);
        dsr_r <= NB'({den_r, 1'b0});
        rem_r <= '0;
        q_r   <= '0;
        dcnt_r <= ($clog2(NB+1))'(NB);
      end
      ST_DIV: begin
        dcnt_r <= dcnt_r - 1'b1;
        dvd_r  <= {dvd_r[NB-2:0], 1'b0};
        if (!trial[NB]) begin
          rem_r <= trial[NB-1:0];
          q_r   <= {q_r[QB-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[NB-2:0], dvd_r[NB-1]};
          q_r   <= {q_r[QB-2:0], 1'b0};
        end
      end
      ST_READ: idx_r <= AW'(qclamp);
      ST_WRITE: cnt_r <= inc;
      default: ;
    endcase
  end

endmodule

// ===== sim/annular_arc_angular_binning_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annular_arc_angular_binning_test
// Checks annular sector membership, bin selection and histogram counts of the
// binning block against a local predictor, over several register settings,
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module annular_arc_angular_binning_test;
  import aab_pkg::*;

  localparam int  NBINS      = 16384;
  localparam int  PI_Q       = 25736;
  localparam int  FRAC_SHIFT = 30 - 13;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic signed [11:0] row;
    logic signed [11:0] col;
  } pixel_t;

  typedef struct packed {
    logic        hit;
    logic [13:0] bin;
    logic [23:0] total;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = CFG_INNER;
  logic [16:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [11:0] in_row_offset = '0;
  logic signed [11:0] in_col_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_inside_res;
  logic [13:0] out_bin_index;
  logic [23:0] out_bin_total;

  annular_arc_angular_binning dut (.*);

  always #5 clk = ~clk;

  // predictor copy of registers and histogram
  logic [10:0] p_inner, p_outer;
  logic signed [15:0] p_start;
  logic signed [16:0] p_sweep;
  logic [14:0] p_bins;
  logic [23:0] p_hist [NBINS];

  pixel_t pixel_q[$];
  hit_t   hit_q[$];
  int     mismatches = 0;
  bit     in_fire = 1'b0;
  longint cycles = 0;
  int     in_gap = 0, out_gap = 0;

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_q30_of(int i);
    longint tbl [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tbl[i];
    return longint'(1) << (30 - i);
  endfunction

  // CORDIC vectoring on (col, -row), Q30 result
  function automatic longint pixel_angle_q30(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return -64'sd1686629713;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
      x = -x;
      y = -y;
    end
    x = x <<< 40;
    y = y <<< 40;
    for (int i = 0; i < 30; i++) begin
      xs = fshr(x, i);
      ys = fshr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_q30_of(i);
      end else begin
        x -= ys; y += xs; z -= atan_q30_of(i);
      end
    end
    return z;
  endfunction

  function automatic longint round_angle(longint v);
    longint h;
    h = longint'(1) << (FRAC_SHIFT - 1);
    if (v >= 0) return (v + h) >>> FRAC_SHIFT;
    return -((-v + h) >>> FRAC_SHIFT);
  endfunction

  function automatic bit in_arc(longint a, longint b, longint t);
    return (a <= t && t < b) || (b < t && t <= a);
  endfunction

  function automatic hit_t bin_pixel(pixel_t p);
    hit_t h;
    longint r, c, d2, t, a, sw, b, num, den, nb, idx;
    h = '0;
    r = p.row;
    c = p.col;
    d2 = r * r + c * c;
    if (d2 > longint'(p_outer) * p_outer || d2 < longint'(p_inner) * p_inner) return h;
    t = round_angle(pixel_angle_q30(c, -r));
    if (t > PI_Q) t -= 2 * PI_Q;
    if (t <= -PI_Q) t += 2 * PI_Q;
    a = p_start;
    sw = p_sweep;
    b = a + sw;
    if (!(in_arc(a, b, t - 2 * PI_Q) || in_arc(a, b, t) || in_arc(a, b, t + 2 * PI_Q)))
      return h;
    if (sw == 0) return h;
    if (sw > 0 && t < a) t += 2 * PI_Q;
    else if (sw < 0 && t > a) t -= 2 * PI_Q;
    num = (t < a) ? a - t : t - a;
    den = (sw < 0) ? -sw : sw;
    nb = p_bins;
    if (nb < 1) nb = 1;
    if (nb > NBINS) nb = NBINS;
    idx = (2 * num * (nb - 1) + den) / (2 * den);
    if (idx > nb - 1) idx = nb - 1;
    if (p_hist[idx] != COUNT_MAX) p_hist[idx]++;
    h.hit = 1'b1;
    h.bin = idx[13:0];
    h.total = p_hist[idx];
    return h;
  endfunction

  // driver: new request goes up on a falling edge after a random gap
  always @(negedge clk) begin
    bit send, acc;
    pixel_t cur;
    if (rst_n) begin
      send = 1'b0;
      acc = in_fire;
      if (in_fire) begin
        in_fire = 1'b0;
        in_gap = $urandom_range(0, 12);
        send = (in_gap == 0);
      end else if (!in_valid) begin
        if (in_gap > 0) in_gap--;
        else send = 1'b1;
      end
      if (send && pixel_q.size() > 0) begin
        cur = pixel_q.pop_front();
        in_row_offset <= cur.row;
        in_col_offset <= cur.col;
        hit_q = {hit_q, bin_pixel(cur)};
        in_valid <= 1'b1;
      end else if (acc) begin
        in_valid <= 1'b0;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (rst_n && in_valid && in_ready) in_fire = 1'b1;
    if (rst_n && out_valid && out_ready) begin
      out_gap = $urandom_range(0, 12);
      if (hit_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %b %0d %0d",
                                       out_inside_res, out_bin_index, out_bin_total);
      end else begin
        hit_t e;
        e = hit_q.pop_front();
        if (e.hit !== out_inside_res || e.bin !== out_bin_index ||
            e.total !== out_bin_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %b/%0d/%0d got %b/%0d/%0d", e.hit, e.bin,
                     e.total, out_inside_res, out_bin_index, out_bin_total);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pixel_q.size() > 0 || hit_q.size() > 0 || in_valid) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_INNER: p_inner = val[10:0];
      CFG_OUTER: p_outer = val[10:0];
      CFG_START: p_start = val[15:0];
      CFG_SWEEP: p_sweep = val;
      default:   p_bins = val[14:0];
    endcase
  endtask

  task automatic push_pixel(int r, int c);
    pixel_t p;
    p.row = r[11:0];
    p.col = c[11:0];
    pixel_q = {pixel_q, p};
  endtask

  // mostly pixels in the annulus, some anywhere
  task automatic random_pixels(int n);
    int rad, r, c;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        r = $signed(12'($urandom));
        c = $signed(12'($urandom));
      end else begin
        rad = $urandom_range(p_inner, p_outer);
        r = $urandom_range(0, 2 * rad) - rad;
        c = $urandom_range(0, 2 * rad) - rad;
        if (r > 2047) r = 2047;
        if (c > 2047) c = 2047;
        if (r < -2048) r = -2048;
        if (c < -2048) c = -2048;
      end
      push_pixel(r, c);
    end
  endtask

  initial begin
    p_inner = 0; p_outer = 1; p_start = 0; p_sweep = 25736; p_bins = 1;
    foreach (p_hist[i]) p_hist[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults: centre and unit neighbours
    push_pixel(0, 0); push_pixel(1, 0); push_pixel(0, 1); push_pixel(-1, 0);
    push_pixel(0, -1); push_pixel(1, 1);
    wait_drained();

    // full annulus, many bins, extreme offsets
    write_reg(CFG_INNER, 17'd0); write_reg(CFG_OUTER, 17'd2047);
    write_reg(CFG_START, 17'(-25735)); write_reg(CFG_SWEEP, 17'(51472));
    write_reg(CFG_BINS, 17'd16384);
    push_pixel(-2048, -2048); push_pixel(2047, 2047); push_pixel(-2048, 0);
    push_pixel(0, 2047); push_pixel(2047, 0); push_pixel(0, -2048);
    push_pixel(-1000, 5); push_pixel(1000, -5); push_pixel(3, 3);
    wait_drained();

    // zero sweep, out-of-range bins, negative sweep, inverted radii
    write_reg(CFG_SWEEP, 17'd0);
    push_pixel(10, 10); push_pixel(-10, 3);
    wait_drained();
    write_reg(CFG_BINS, 17'd0); write_reg(CFG_SWEEP, 17'(-51472));
    write_reg(CFG_START, 17'd25736);
    push_pixel(100, 0); push_pixel(-100, 0); push_pixel(0, 100);
    wait_drained();
    write_reg(CFG_BINS, 17'h7FFF); write_reg(CFG_INNER, 17'd50);
    write_reg(CFG_OUTER, 17'd20);
    push_pixel(30, 0); push_pixel(0, 30);
    wait_drained();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_INNER, 17'($urandom_range(0, 60)));
      write_reg(CFG_OUTER, (ph == 7) ? 17'd2047 : 17'($urandom_range(61, 300)));
      write_reg(CFG_START, 17'($urandom_range(0, 51471) - 25735));
      write_reg(CFG_SWEEP, 17'($urandom_range(0, 102944) - 51472));
      write_reg(CFG_BINS, (ph % 3 == 0) ? 17'($urandom_range(1, 8))
                                        : 17'($urandom_range(1, 16384)));
      random_pixels(80);
      wait_drained();
    end

    wait_drained();
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/aab_pkg.sv
rtl/aab_ram.sv
rtl/annular_arc_angular_binning.sv
sim/annular_arc_angular_binning_test.sv
